FILE: rtl/pst_pkg.sv
// types and constants shared by the palindromic tree builder
package pst_pkg;

	localparam int SYM_IN_W = 8;
	localparam int OUT_W    = 11;

	typedef struct packed {
		logic [SYM_IN_W-1:0] symbol;
		logic                restart;
	} pst_in_t;

	typedef struct packed {
		logic [OUT_W-1:0] suffix_node;
		logic [OUT_W-1:0] suffix_length;
		logic [OUT_W-1:0] suffix_link_out;
		logic             created;
		logic [OUT_W-1:0] nodes_used;
		logic             overflow;
	} pst_out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WRD,
		S_WLEN,
		S_WCMP,
		S_TRD,
		S_TCHK,
		S_TVAL,
		S_ORD,
		S_ODAT
	} pst_state_t;

endpackage

FILE: rtl/palindromic_suffix_tree_builder.sv
// top level: eertree builder with a link-walk sequencer over node and history rams
//
// Each symbol is taken when sym_ready is high and gives one result item. A symbol passes
// the accept and output states (S_IDLE, S_ORD, S_ODAT), and for each suffix link walk
// the transition lookup states (S_TRD, S_TCHK, S_TVAL) and, for every node tried, S_WRD,
// S_WLEN and S_WCMP (S_WRD alone for the imaginary root, S_WRD and S_WLEN for a node too
// long to extend). A new node longer than one runs a second walk. The walk loop makes one
// memory read per cycle. A symbol that finds the string full goes from accept straight
// to output with no walk. A result item still waiting in the output register holds the
// next one in its last cycle. Transition entries are checked against each node's parent
// and edge symbol, so a restart takes effect at once with no clearing pass.
module palindromic_suffix_tree_builder
	import pst_pkg::*;
#(
	parameter int MAX_LENGTH  = 1024,
	parameter int SYMBOL_BITS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     sym_valid,
	output logic     sym_ready,
	input  pst_in_t  sym,
	output logic     res_valid,
	input  logic     res_ready,
	output pst_out_t res
);

	localparam int NODE_SLOTS = MAX_LENGTH + 3;
	localparam int NW         = $clog2(NODE_SLOTS);
	localparam int PW         = $clog2(MAX_LENGTH + 1);
	localparam int HAW        = $clog2(MAX_LENGTH);
	localparam int SYM_COUNT  = 1 << SYMBOL_BITS;
	localparam int TAW        = $clog2(NODE_SLOTS * SYM_COUNT);

	localparam logic [NW-1:0] NODE_IMAG  = NW'(1);
	localparam logic [NW-1:0] NODE_EMPTY = NW'(2);
	localparam logic [NW-1:0] NODE_LIM   = NW'(MAX_LENGTH + 2);

	pst_state_t state_q, state_d;

	logic [SYMBOL_BITS-1:0] c_q;
	logic [PW-1:0]          pos_q;
	logic [NW-1:0]          cnt_q;
	logic [NW-1:0]          last_q;
	logic [NW-1:0]          n_q;
	logic                   mode_q;
	logic [NW-1:0]          tnode_q;
	logic signed [PW:0]     cur_len_q;
	logic [NW-1:0]          cur_link_q;
	logic [PW-1:0]          lenw_q;
	logic [NW-1:0]          linkw_q;
	logic [NW-1:0]          cand_q;
	logic                   created_q;
	logic                   ovf_q;
	logic                   res_valid_q;
	pst_out_t               res_q;

	logic                   hist_we;
	logic [HAW-1:0]         hist_waddr;
	logic [HAW-1:0]         hist_raddr;
	logic [SYMBOL_BITS-1:0] hist_rd;
	logic                   node_we;
	logic                   link_we;
	logic [NW-1:0]          link_waddr;
	logic [NW-1:0]          link_wdata;
	logic [NW-1:0]          node_raddr;
	logic [PW-1:0]          len_rd;
	logic [NW-1:0]          link_rd;
	logic [NW-1:0]          trans_rd;
	logic [NW-1:0]          par_rd;
	logic [SYMBOL_BITS-1:0] esym_rd;
	logic [TAW-1:0]         trans_raddr;

	logic [SYMBOL_BITS-1:0] c_in;
	logic [PW-1:0]          pos_eff;
	logic [NW-1:0]          last_eff;
	logic [PW-1:0]          len_n;
	logic [NW-1:0]          link_n;
	logic signed [PW:0]     k;
	logic                   hit;
	logic signed [PW:0]     new_len;
	logic [NW-1:0]          nn;
	logic                   room;
	logic                   emit_ok;

	assign c_in     = sym.symbol[SYMBOL_BITS-1:0];
	assign pos_eff  = sym.restart ? '0 : pos_q;
	assign last_eff = sym.restart ? NODE_EMPTY : last_q;
	assign len_n    = (n_q == NODE_EMPTY) ? '0 : len_rd;
	assign link_n   = (n_q == NODE_EMPTY) ? NODE_IMAG : link_rd;
	assign k        = $signed({1'b0, pos_q}) - $signed({1'b0, len_n}) - (PW+1)'(1);
	assign hit      = (cand_q > NODE_EMPTY) && (cand_q <= cnt_q) && (par_rd == tnode_q)
	                  && (esym_rd == c_q);
	assign new_len  = cur_len_q + (PW+1)'(2);
	assign nn       = cnt_q + NW'(1);
	assign room     = cnt_q < NODE_LIM;
	assign emit_ok  = !res_valid_q || res_ready;

	assign hist_waddr  = pos_eff[HAW-1:0];
	assign hist_raddr  = k[HAW-1:0];
	assign trans_raddr = TAW'({tnode_q, c_q});
	assign node_raddr  = (state_q == S_WRD) ? n_q : last_q;

	always_comb begin
		state_d    = state_q;
		hist_we    = 1'b0;
		node_we    = 1'b0;
		link_we    = 1'b0;
		link_waddr = nn;
		link_wdata = NODE_EMPTY;
		sym_ready  = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (sym_valid) begin
					if (pos_eff == PW'(MAX_LENGTH)) begin
						state_d = S_ORD;
					end else begin
						hist_we = 1'b1;
						state_d = S_WRD;
					end
				end
			end
			S_WRD: begin
				state_d = (n_q == NODE_IMAG) ? S_TRD : S_WLEN;
			end
			S_WLEN: begin
				state_d = k[PW] ? S_WRD : S_WCMP;
			end
			S_WCMP: begin
				state_d = (hist_rd == c_q) ? S_TRD : S_WRD;
			end
			S_TRD: begin
				state_d = S_TCHK;
			end
			S_TCHK: begin
				state_d = S_TVAL;
			end
			S_TVAL: begin
				state_d = S_ORD;
				if (mode_q) begin
					link_we    = 1'b1;
					link_waddr = last_q;
					if (hit) begin
						link_wdata = cand_q;
					end
				end else if (hit) begin
					state_d = S_ORD;
				end else if (room) begin
					node_we = 1'b1;
					if (new_len == (PW+1)'(1)) begin
						link_we = 1'b1;
					end else begin
						state_d = S_WRD;
					end
				end
			end
			S_ORD: begin
				state_d = S_ODAT;
			end
			S_ODAT: begin
				if (emit_ok) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			cnt_q       <= NODE_EMPTY;
			last_q      <= NODE_EMPTY;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_ODAT && emit_ok) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (sym_valid) begin
						pos_q  <= pos_eff;
						last_q <= last_eff;
						if (sym.restart) begin
							cnt_q <= NODE_EMPTY;
						end
					end
				end
				S_TVAL: begin
					if (!mode_q) begin
						if (hit) begin
							last_q <= cand_q;
						end else if (room) begin
							cnt_q  <= nn;
							last_q <= nn;
						end
					end
				end
				S_ODAT: begin
					if (emit_ok && !ovf_q) begin
						pos_q <= pos_q + PW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				c_q       <= c_in;
				n_q       <= last_eff;
				mode_q    <= 1'b0;
				created_q <= 1'b0;
				ovf_q     <= (pos_eff == PW'(MAX_LENGTH));
			end
			S_WRD: begin
				if (n_q == NODE_IMAG) begin
					tnode_q <= n_q;
					if (!mode_q) begin
						cur_len_q  <= -(PW+1)'(1);
						cur_link_q <= NODE_IMAG;
					end
				end
			end
			S_WLEN: begin
				lenw_q  <= len_n;
				linkw_q <= link_n;
				if (k[PW]) begin
					n_q <= link_n;
				end
			end
			S_WCMP: begin
				if (hist_rd == c_q) begin
					tnode_q <= n_q;
					if (!mode_q) begin
						cur_len_q  <= $signed({1'b0, lenw_q});
						cur_link_q <= linkw_q;
					end
				end else begin
					n_q <= linkw_q;
				end
			end
			S_TCHK: begin
				cand_q <= trans_rd;
			end
			S_TVAL: begin
				if (!mode_q && !hit && room) begin
					created_q <= 1'b1;
					mode_q    <= 1'b1;
					n_q       <= cur_link_q;
				end
			end
			S_ODAT: begin
				if (emit_ok) begin
					res_q.suffix_node     <= OUT_W'(last_q);
					res_q.suffix_length   <= (last_q == NODE_IMAG) ? '1 :
					                         (last_q == NODE_EMPTY) ? '0 : OUT_W'(len_rd);
					res_q.suffix_link_out <= (last_q == NODE_IMAG || last_q == NODE_EMPTY)
					                         ? OUT_W'(NODE_IMAG) : OUT_W'(link_rd);
					res_q.created         <= created_q;
					res_q.nodes_used      <= OUT_W'(cnt_q);
					res_q.overflow        <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	pst_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LENGTH)) u_hist (
		.clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(c_in),
		.raddr(hist_raddr), .rdata(hist_rd)
	);

	pst_ram #(.WIDTH(PW), .DEPTH(NODE_SLOTS)) u_len (
		.clk(clk), .we(node_we), .waddr(nn), .wdata(new_len[PW-1:0]),
		.raddr(node_raddr), .rdata(len_rd)
	);

	pst_ram #(.WIDTH(NW), .DEPTH(NODE_SLOTS)) u_link (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.raddr(node_raddr), .rdata(link_rd)
	);

	pst_ram #(.WIDTH(NW), .DEPTH(NODE_SLOTS * SYM_COUNT)) u_trans (
		.clk(clk), .we(node_we), .waddr(trans_raddr), .wdata(nn),
		.raddr(trans_raddr), .rdata(trans_rd)
	);

	pst_ram #(.WIDTH(NW), .DEPTH(NODE_SLOTS)) u_par (
		.clk(clk), .we(node_we), .waddr(nn), .wdata(tnode_q),
		.raddr(trans_rd), .rdata(par_rd)
	);

	pst_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(NODE_SLOTS)) u_esym (
		.clk(clk), .we(node_we), .waddr(nn), .wdata(c_q),
		.raddr(trans_rd), .rdata(esym_rd)
	);

	a_last_range: assert property (@(posedge clk) disable iff (!arst_n)
		last_q >= NODE_IMAG && last_q <= cnt_q)
		else $error("suffix node outside allocated range");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(MAX_LENGTH))
		else $error("position beyond capacity");

	a_ovf_nocreate: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.overflow |-> !res_q.created)
		else $error("overflow item reports a new node");

	a_cnt_grow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TVAL && !mode_q && !hit && room |=> cnt_q == $past(cnt_q) + NW'(1))
		else $error("node count did not advance on creation");

endmodule

FILE: rtl/pst_ram.sv
// generic single write, single registered read ram
module pst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
